>>> hdl/sfia_pkg.sv
// Shared types and codes for the smallest free identifier allocator.
`default_nettype none

package sfia_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } state_t;

    localparam logic CMD_TAKE = 1'b0;
    localparam logic CMD_GIVE = 1'b1;

    localparam logic [1:0] STAT_TAKEN     = 2'd0;
    localparam logic [1:0] STAT_GIVEN     = 2'd1;
    localparam logic [1:0] STAT_IGNORED   = 2'd2;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

    localparam int WORD_BITS = 64;
    localparam int BIT_IDX_W = 6;
    localparam int IDENT_W   = 11;

endpackage

`default_nettype wire

>>> hdl/smallest_free_id_allocator_top.sv
// Smallest free identifier allocator: bitmap RAM with per-word full marks.
// A command's bitmap word is read from the single RAM when the command is accepted
// and written back, if changed, in the modify state, where the result is registered.
// A new command is accepted only after the last one has left the modify state.
// Reset: full marks clear at once; a clearing pass then zeroes the bitmap RAM,
// one word a cycle, ceil(ID_COUNT/64) words, and no command is accepted meanwhile.
`default_nettype none

module smallest_free_id_allocator_top #(
    parameter int ID_COUNT = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [10:0] ident,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [10:0] ident_out,
    output logic      [1:0]  status
);

    import sfia_pkg::*;

    localparam int WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EW    = (WAW + BIT_IDX_W > IDENT_W) ? WAW + BIT_IDX_W : IDENT_W;
    localparam int REM   = ID_COUNT % WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        (REM == 0) ? {WORD_BITS{1'b1}} : ((WORD_BITS'(1) << REM) - WORD_BITS'(1));
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

    state_t                 state_reg, state_next;
    logic [WAW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [WORDS-1:0]       full_reg, full_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IDENT_W-1:0]     ident_out_reg, ident_out_next;
    logic [1:0]             status_reg, status_next;
    logic                   cmd_reg, cmd_next;
    logic                   skip_reg, skip_next;
    logic [WAW-1:0]         word_reg, word_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;

    logic                   ram_we;
    logic [WAW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [WAW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    logic                   all_full;
    logic [WAW-1:0]         first_free;
    logic [EW-1:0]          idx_ext;
    logic                   in_range;
    logic [WORD_BITS-1:0]   vmask;
    logic [WORD_BITS-1:0]   free_bits;
    logic [WORD_BITS-1:0]   set_word;
    logic [BIT_IDX_W-1:0]   free_bit;
    logic [WAW+BIT_IDX_W:0] taken_id;
    logic                   go;

    sfia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WAW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lowest word whose full mark is clear
    always_comb
    begin
        all_full   = &full_reg;
        first_free = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                first_free = WAW'(i);
            end
        end
    end

    // lowest free bit of the word just read
    always_comb
    begin
        vmask     = (word_reg == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
        free_bits = ~ram_rdata & vmask;
        free_bit  = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                free_bit = BIT_IDX_W'(i);
            end
        end
        set_word = ram_rdata | (WORD_BITS'(1) << free_bit);
        taken_id = {1'b0, word_reg, free_bit} + (WAW + BIT_IDX_W + 1)'(1);
    end

    assign idx_ext  = EW'(ident) - EW'(1);
    assign in_range = (ident != '0) && (32'(ident) <= 32'(ID_COUNT));
    assign go       = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ident_out_next = ident_out_reg;
        status_next    = status_reg;
        cmd_next       = cmd_reg;
        skip_next      = skip_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + WAW'(1);
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = command;
                    bit_next = idx_ext[BIT_IDX_W-1:0];
                    if (command == CMD_TAKE)
                    begin
                        word_next = first_free;
                        skip_next = all_full;
                    end
                    else
                    begin
                        word_next = idx_ext[WAW+BIT_IDX_W-1:BIT_IDX_W];
                        skip_next = !in_range;
                    end
                    ram_re     = 1'b1;
                    ram_raddr  = word_next;
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                // hold until the output register is free
                if (go)
                begin
                    out_valid_next = 1'b1;
                    ident_out_next = '0;
                    state_next     = ST_IDLE;
                    if (cmd_reg == CMD_TAKE)
                    begin
                        if (skip_reg)
                        begin
                            status_next = STAT_EXHAUSTED;
                        end
                        else if (free_bits == '0)
                        begin
                            // repair a stale mark
                            full_next[word_reg] = 1'b1;
                            status_next         = STAT_EXHAUSTED;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            ram_wdata           = set_word;
                            full_next[word_reg] = ((set_word & vmask) == vmask);
                            ident_out_next      = IDENT_W'(taken_id);
                            status_next         = STAT_TAKEN;
                        end
                    end
                    else
                    begin
                        if (skip_reg || !ram_rdata[bit_reg])
                        begin
                            status_next = STAT_IGNORED;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            ram_wdata           = ram_rdata & ~(WORD_BITS'(1) << bit_reg);
                            full_next[word_reg] = 1'b0;
                            status_next         = STAT_GIVEN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_out_reg <= ident_out_next;
        status_reg    <= status_next;
        cmd_reg       <= cmd_next;
        skip_reg      <= skip_next;
        word_reg      <= word_next;
        bit_reg       <= bit_next;
    end

    assign out_valid = out_valid_reg;
    assign ident_out = ident_out_reg;
    assign status    = status_reg;

    a_result_from_modify: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_MODIFY))
        else $error("result appeared without a modify cycle");

    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("bitmap write while idle");

    a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY && out_valid_reg && !out_ready) |-> !ram_we)
        else $error("bitmap written while result is stalled");

    a_zero_ident_unless_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STAT_TAKEN) |-> (ident_out_reg == '0))
        else $error("nonzero identifier on a result that took none");

    a_taken_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (ID_COUNT < 2048 && out_valid_reg && status_reg == STAT_TAKEN)
            |-> (ident_out_reg != '0))
        else $error("taken identifier is zero");

endmodule

`default_nettype wire

>>> hdl/sfia_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module sfia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data between reads
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
